/* hw/rtl/assert_macros.svh */
// Assertion macros used by the allocator controller (bma_ctrl).
// No dependencies; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error("%m failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

/* hw/rtl/bma_pkg.sv */
// Types, codes and constants of the buddy allocator.
// No dependencies.
package bma_pkg;
    localparam int unsigned HDR = 16;

    localparam logic [0:0] KIND_ALLOC = 1'b0;
    localparam logic [0:0] KIND_FREE  = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ZERO   = 2'd1;
    localparam logic [1:0] ST_BIG    = 2'd2;
    localparam logic [1:0] ST_NOBLK  = 2'd3;

    typedef struct packed {
        logic [0:0]  kind;
        logic [29:0] request_length;
        logic [29:0] release_offset;
    } req_t;

    typedef struct packed {
        logic [29:0] payload_offset;
        logic [1:0]  status;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_SCAN, S_SPLIT, S_GRANT,
        S_FLVL, S_FREAD, S_FMERGE, S_FSET, S_OUT
    } state_t;

    typedef struct packed {
        logic clear_start;
        logic load;
        logic check;
        logic scan_step;
        logic split_step;
        logic grant;
        logic flvl;
        logic fread;
        logic fmerge;
        logic fset;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_free;
        logic early_fail;
        logic scan_found;
        logic scan_fail;
        logic split_done;
        logic merge_go;
    } sts_t;
endpackage

/* hw/rtl/buddy_memory_allocator_core.sv */
// Binary buddy allocator over a pool of basic blocks.
// Requests arrive on in_valid/in_ready as bma_pkg::req_t; each gives one
// response on out_valid/out_ready as bma_pkg::rsp_t.
// Allocate: check, node scan, then split down the levels; the free-bit
// memory read port sets the scan pace. Free: level lookup, then a buddy read and merge per merged level, then set.
// One request is in work at a time; the response register holds the
// result while the next request is taken.
// Reset and a configuration write in the idle state start a clearing pass
// over the free-bit memory; no request is taken then. Configuration is
// written via cfg_we/cfg_index/cfg_data.
// A stalled receiver holds the response; the core waits before loading
// the next one.
module buddy_memory_allocator_core #(
    parameter int MAX_ORDER    = 10,
    parameter int HEADER_BYTES = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_index,
    input  logic [4:0]      cfg_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  bma_pkg::req_t   in_req,
    output logic            out_valid,
    input  logic            out_ready,
    output bma_pkg::rsp_t   out_rsp
);
    logic [4:0]    bs_reg;
    logic [3:0]    po_reg;
    bma_pkg::req_t req_reg;
    bma_pkg::cmd_t cmd;
    bma_pkg::sts_t sts;
    bma_pkg::rsp_t rsp;
    logic          rsp_load;
    logic          ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg <= 5'd7;
            po_reg <= 4'd10;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == 1'b0)
                bs_reg <= cfg_data;
            if (cfg_we && cfg_index == 1'b1)
                po_reg <= cfg_data[3:0];
            if (rsp_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            req_reg <= in_req;
        if (rsp_load)
            out_rsp <= rsp;
    end

    assign out_valid = ov_reg;

    bma_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .in_valid(in_valid),
        .in_ready(in_ready), .rsp_load(rsp_load), .out_busy(ov_reg && !out_ready),
        .cmd(cmd), .sts(sts));

    bma_dp #(.MAX_ORDER(MAX_ORDER), .HEADER_BYTES(HEADER_BYTES)) u_dp (
        .clk(clk), .rst_n(rst_n), .bs(bs_reg), .pord(po_reg), .req(req_reg),
        .cmd(cmd), .sts(sts), .rsp(rsp));
endmodule

/* hw/rtl/bma_ram.sv */
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module bma_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/bma_ctrl.sv */
// Controller state machine of the buddy allocator.
// Depends on bma_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bma_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              rsp_load,
    input  logic              out_busy,
    output bma_pkg::cmd_t     cmd,
    input  bma_pkg::sts_t     sts
);
    bma_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bma_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        rsp_load = 1'b0;
        case (state_reg)
            bma_pkg::S_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = bma_pkg::S_IDLE;
                end
            end
            bma_pkg::S_IDLE:
            begin
                in_ready = !cfg_we;
                if (cfg_we)
                begin
                    cmd.clear_start = 1'b1;
                    state_next = bma_pkg::S_CLEAR;
                end
                else if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = bma_pkg::S_CHECK;
                end
            end
            bma_pkg::S_CHECK:
            begin
                cmd.check = 1'b1;
                if (sts.is_free)
                begin
                    state_next = bma_pkg::S_FLVL;
                end
                else if (sts.early_fail)
                begin
                    state_next = bma_pkg::S_OUT;
                end
                else
                begin
                    state_next = bma_pkg::S_SCAN;
                end
            end
            bma_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_found)
                begin
                    state_next = bma_pkg::S_SPLIT;
                end
                else if (sts.scan_fail)
                begin
                    state_next = bma_pkg::S_OUT;
                end
            end
            bma_pkg::S_SPLIT:
            begin
                if (sts.split_done)
                begin
                    cmd.grant = 1'b1;
                    state_next = bma_pkg::S_OUT;
                end
                else
                begin
                    cmd.split_step = 1'b1;
                end
            end
            bma_pkg::S_FLVL:
            begin
                cmd.flvl = 1'b1;
                state_next = bma_pkg::S_FREAD;
            end
            bma_pkg::S_FREAD:
            begin
                cmd.fread = 1'b1;
                state_next = bma_pkg::S_FMERGE;
            end
            bma_pkg::S_FMERGE:
            begin
                cmd.fmerge = 1'b1;
                if (sts.merge_go)
                begin
                    state_next = bma_pkg::S_FREAD;
                end
                else
                begin
                    state_next = bma_pkg::S_FSET;
                end
            end
            bma_pkg::S_FSET:
            begin
                cmd.fset = 1'b1;
                state_next = bma_pkg::S_OUT;
            end
            bma_pkg::S_OUT:
            begin
                if (!out_busy)
                begin
                    rsp_load = 1'b1;
                    state_next = bma_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bma_pkg::S_IDLE;
            end
        endcase
    end

    `ASSERT_CLK(a_ready_idle, clk, rst_n, in_ready |-> (state_reg == bma_pkg::S_IDLE))
    `ASSERT_NEXT(a_load_check, clk, rst_n, cmd.load, state_reg == bma_pkg::S_CHECK)
    `ASSERT_NEXT(a_cfg_clear, clk, rst_n, cmd.clear_start, state_reg == bma_pkg::S_CLEAR)
endmodule

/* hw/rtl/bma_dp.sv */
// Datapath of the buddy allocator: free-bit memory, level memory, search.
// Depends on bma_pkg and bma_ram.
module bma_dp #(
    parameter int MAX_ORDER    = 10,
    parameter int HEADER_BYTES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [4:0]        bs,
    input  logic [3:0]        pord,
    input  bma_pkg::req_t     req,
    input  bma_pkg::cmd_t     cmd,
    output bma_pkg::sts_t     sts,
    output bma_pkg::rsp_t     rsp
);
    localparam int NA = MAX_ORDER + 1;
    localparam int LA = (MAX_ORDER > 0) ? MAX_ORDER : 1;
    localparam int LW = $clog2(MAX_ORDER + 1);
    localparam int NODES = 2 << MAX_ORDER;
    localparam int LEAVES = 1 << MAX_ORDER;

    logic [LW-1:0]  top;
    logic [LW-1:0]  lvl_reg, need_reg, cur_reg;
    logic [LA-1:0]  pos_reg;
    logic [NA-1:0]  caddr_reg;
    logic [NA:0]    clr_cnt_reg;
    logic           clearing_reg;
    logic [1:0]     rdv_reg;
    logic [29:0]    off_reg;
    logic [1:0]     st_reg;

    logic           fm_we;
    logic [NA-1:0]  fm_waddr, fm_raddr;
    logic           fm_wdata, fm_rdata;
    logic           gl_we;
    logic [LA-1:0]  gl_waddr, gl_raddr;
    logic [LW-1:0]  gl_wdata, gl_rdata;

    assign top = (int'(pord) > MAX_ORDER) ? LW'(MAX_ORDER) : LW'(pord);

    function automatic logic [NA-1:0] node(input logic [LW-1:0] t, input logic [LW-1:0] l,
                                          input logic [LA-1:0] p);
        logic [NA:0] s;
        s = ((NA+1)'(1) << (t - l)) + (NA+1)'(p);
        return s[NA-1:0];
    endfunction

    // request decode
    logic [30:0] need;
    logic [5:0]  k;
    logic [5:0]  lv;
    logic        len_big;
    logic [29:0] start;
    logic [LA-1:0] fidx;
    always_comb
    begin
        need = {1'b0, req.request_length} + 31'(HEADER_BYTES);
        k = 6'd0;
        for (int i = 0; i < 31; i++)
        begin
            if (need > (31'(1) << i))
            begin
                k = 6'(i + 1);
            end
        end
        lv = (k > {1'b0, bs}) ? k - {1'b0, bs} : 6'd0;
        len_big = ({34'b0, req.request_length} > (64'd1 << ({1'b0, bs} + 6'(top))));
        start = req.release_offset - 30'(HEADER_BYTES);
        fidx = LA'(start >> bs) & LA'((LEAVES - 1) >> (LW'(MAX_ORDER) - top));
    end

    // scan: cur level, pos; read address issued before the data is checked
    logic [LA-1:0] cnt_lim;
    assign cnt_lim = LA'((1 << (MAX_ORDER)) >> (LW'(MAX_ORDER) - top + cur_reg) ) - LA'(1);

    assign sts.clear_done = !clearing_reg && !cmd.clear_start;
    assign sts.is_free = (req.kind == bma_pkg::KIND_FREE);
    assign sts.early_fail = (req.request_length == 30'd0) || len_big || (lv > 6'(top));
    assign sts.scan_found = rdv_reg[1] && fm_rdata;
    assign sts.scan_fail = rdv_reg[1] && !fm_rdata && (pos_reg == cnt_lim) && (cur_reg == top);
    assign sts.split_done = (cur_reg == need_reg);
    assign sts.merge_go = (lvl_reg < top) && fm_rdata;

    always_comb
    begin
        fm_we = 1'b0;
        fm_waddr = caddr_reg;
        fm_wdata = 1'b0;
        fm_raddr = node(top, cur_reg, pos_reg);
        gl_we = 1'b0;
        gl_waddr = LA'(pos_reg << need_reg);
        gl_wdata = need_reg;
        gl_raddr = fidx;
        if (clearing_reg)
        begin
            fm_we = 1'b1;
            fm_wdata = (caddr_reg == NA'(1));
        end
        else if (cmd.scan_step && sts.scan_found)
        begin
            fm_we = 1'b1;
            fm_waddr = node(top, cur_reg, pos_reg);
        end
        else if (cmd.split_step)
        begin
            fm_we = 1'b1;
            fm_wdata = 1'b1;
            fm_waddr = node(top, cur_reg - LW'(1), LA'({pos_reg, 1'b1}));
        end
        else if (cmd.grant)
        begin
            gl_we = 1'b1;
        end
        else if (cmd.fread)
        begin
            fm_raddr = node(top, lvl_reg, pos_reg ^ LA'(1));
        end
        else if (cmd.fmerge && sts.merge_go)
        begin
            fm_we = 1'b1;
            fm_waddr = node(top, lvl_reg, pos_reg ^ LA'(1));
        end
        else if (cmd.fset)
        begin
            fm_we = 1'b1;
            fm_wdata = 1'b1;
            fm_waddr = node(top, lvl_reg, pos_reg);
        end
    end

    bma_ram #(.W(1), .D(NODES)) u_fm (
        .clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
        .raddr(fm_raddr), .rdata(fm_rdata));

    bma_ram #(.W(LW), .D(LEAVES)) u_gl (
        .clk(clk), .we(gl_we), .waddr(gl_waddr), .wdata(gl_wdata),
        .raddr(gl_raddr), .rdata(gl_rdata));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg <= '0;
            caddr_reg <= '0;
            rdv_reg <= '0;
        end
        else
        begin
            if (cmd.clear_start)
            begin
                clearing_reg <= 1'b1;
                caddr_reg <= '0;
                clr_cnt_reg <= '0;
            end
            else if (clearing_reg)
            begin
                caddr_reg <= caddr_reg + NA'(1);
                clr_cnt_reg <= clr_cnt_reg + (NA+1)'(1);
                if (clr_cnt_reg == (NA+1)'(NODES - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (!cmd.scan_step)
            begin
                rdv_reg <= 2'b00;
            end
            else if (rdv_reg[1] && !sts.scan_found)
            begin
                rdv_reg <= 2'b01;
            end
            else
            begin
                rdv_reg <= {rdv_reg[0], 1'b1};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            st_reg <= bma_pkg::ST_OK;
            off_reg <= '0;
        end
        if (cmd.check)
        begin
            need_reg <= LW'(lv);
            cur_reg <= LW'(lv);
            pos_reg <= '0;
            if (!sts.is_free)
            begin
                if (req.request_length == 30'd0)
                    st_reg <= bma_pkg::ST_ZERO;
                else if (len_big)
                    st_reg <= bma_pkg::ST_BIG;
                else if (lv > 6'(top))
                    st_reg <= bma_pkg::ST_NOBLK;
            end
        end
        if (cmd.scan_step && rdv_reg[1] && !sts.scan_found)
        begin
            if (pos_reg == cnt_lim)
            begin
                if (cur_reg == top)
                    st_reg <= bma_pkg::ST_NOBLK;
                else
                begin
                    cur_reg <= cur_reg + LW'(1);
                    pos_reg <= '0;
                end
            end
            else
            begin
                pos_reg <= pos_reg + LA'(1);
            end
        end
        if (cmd.split_step)
        begin
            cur_reg <= cur_reg - LW'(1);
            pos_reg <= LA'({pos_reg, 1'b0});
        end
        if (cmd.grant)
        begin
            off_reg <= (30'(pos_reg << need_reg) << bs) + 30'(HEADER_BYTES);
        end
        if (cmd.flvl)
        begin
            lvl_reg <= (gl_rdata > top) ? top : gl_rdata;
            pos_reg <= fidx >> ((gl_rdata > top) ? top : gl_rdata);
        end
        if (cmd.fmerge && sts.merge_go)
        begin
            pos_reg <= pos_reg >> 1;
            lvl_reg <= lvl_reg + LW'(1);
        end
    end

    assign rsp.payload_offset = off_reg;
    assign rsp.status = st_reg;
endmodule

/* bench/buddy_memory_allocator_core_test.sv */
// Self-checking bench for buddy_memory_allocator_core: directed table, then
// random alloc/free traffic over several pool settings, checked by a predictor.
// Depends on bma_pkg and the core RTL only.
module buddy_memory_allocator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned MASK30 = 64'h3FFF_FFFF;
    localparam longint CYCLE_LIMIT = 50_000_000;

    typedef struct {
        logic [0:0]  kind;
        logic [29:0] len;
        logic [29:0] off;
        bit          typed;
        logic [29:0] exp_off;
        logic [1:0]  exp_st;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = 1'b0;
    logic [4:0] cfg_data = 5'd0;
    logic in_valid = 1'b0;
    logic in_ready;
    bma_pkg::req_t in_req = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    bma_pkg::rsp_t out_rsp;

    logic       free_bit [0:2047];
    logic [4:0] grant_lvl [0:1023];
    bit         lvl_written [0:1023];
    int unsigned blk_log2;
    int unsigned pool_ord;

    bma_pkg::rsp_t pending_rsp [$];
    logic [29:0]   live_offsets [$];
    int            idle_mode;
    int            mismatches;
    int            responses;
    int            grants;
    int            releases;
    int            refusals;
    longint        cycles = 0;

    row_t plan [18] = '{
        '{bma_pkg::KIND_ALLOC, 30'd0, 30'h3FFFFFFF, 1'b1, 30'd0, bma_pkg::ST_ZERO},
        '{bma_pkg::KIND_ALLOC, 30'h3FFFFFFF, 30'd0, 1'b1, 30'd0, bma_pkg::ST_BIG},
        '{bma_pkg::KIND_ALLOC, 30'd131073, 30'd0, 1'b1, 30'd0, bma_pkg::ST_BIG},
        '{bma_pkg::KIND_ALLOC, 30'd131072, 30'd0, 1'b1, 30'd0, bma_pkg::ST_NOBLK},
        '{bma_pkg::KIND_ALLOC, 30'd1, 30'd0, 1'b1, 30'd16, bma_pkg::ST_OK},
        '{bma_pkg::KIND_ALLOC, 30'd112, 30'd0, 1'b1, 30'd144, bma_pkg::ST_OK},
        '{bma_pkg::KIND_ALLOC, 30'd113, 30'd0, 1'b1, 30'd272, bma_pkg::ST_OK},
        '{bma_pkg::KIND_FREE, 30'h3FFFFFFF, 30'd16, 1'b1, 30'd0, bma_pkg::ST_OK},
        '{bma_pkg::KIND_FREE, 30'd0, 30'd144, 1'b1, 30'd0, bma_pkg::ST_OK},
        '{bma_pkg::KIND_FREE, 30'd0, 30'd272, 1'b1, 30'd0, bma_pkg::ST_OK},
        '{bma_pkg::KIND_ALLOC, 30'd131056, 30'd0, 1'b1, 30'd16, bma_pkg::ST_OK},
        '{bma_pkg::KIND_ALLOC, 30'd1, 30'd0, 1'b1, 30'd0, bma_pkg::ST_NOBLK},
        '{bma_pkg::KIND_FREE, 30'd0, 30'd16, 1'b1, 30'd0, bma_pkg::ST_OK},
        '{bma_pkg::KIND_FREE, 30'd0, 30'd16, 1'b1, 30'd0, bma_pkg::ST_OK},
        '{bma_pkg::KIND_ALLOC, 30'd1000, 30'h3FFFFFFF, 1'b0, 30'd0, bma_pkg::ST_OK},
        '{bma_pkg::KIND_ALLOC, 30'd5000, 30'd0, 1'b0, 30'd0, bma_pkg::ST_OK},
        '{bma_pkg::KIND_ALLOC, 30'd200, 30'd0, 1'b0, 30'd0, bma_pkg::ST_OK},
        '{bma_pkg::KIND_ALLOC, 30'd70000, 30'd0, 1'b0, 30'd0, bma_pkg::ST_OK}
    };

    int unsigned phase_cfg [9][2] = '{
        '{7, 10}, '{4, 0}, '{20, 10}, '{12, 15}, '{4, 10},
        '{9, 3}, '{20, 1}, '{6, 12}, '{16, 6}
    };

    buddy_memory_allocator_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
        .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp)
    );

    always #4 clk = ~clk;

    function automatic int unsigned eff_top();
        return pool_ord > 10 ? 10 : pool_ord;
    endfunction

    function automatic int unsigned node_ix(int unsigned top, int unsigned l, int unsigned p);
        return ((32'd1 << (top - l)) + p) & 32'h7FF;
    endfunction

    function automatic void clear_pool();
        foreach (free_bit[i]) free_bit[i] = 1'b0;
        foreach (grant_lvl[i]) grant_lvl[i] = '0;
        foreach (lvl_written[i]) lvl_written[i] = 1'b0;
        free_bit[1] = 1'b1;
        live_offsets.delete();
    endfunction

    function automatic int unsigned release_index(logic [29:0] off);
        longint unsigned start;
        start = (64'(off) - bma_pkg::HDR) & MASK30;
        return 32'(start >> blk_log2) & ((32'd1 << eff_top()) - 1);
    endfunction

    function automatic bma_pkg::rsp_t buddy_predict(bma_pkg::req_t r);
        bma_pkg::rsp_t res;
        int unsigned top, k, need_lvl, l, p, idx, cnt;
        longint unsigned len, need;
        bit found;
        res = '0;
        top = eff_top();
        found = 0;
        p = 0;
        if (r.kind == bma_pkg::KIND_ALLOC)
        begin
            len = r.request_length;
            if (len == 0)
            begin
                res.status = bma_pkg::ST_ZERO;
                return res;
            end
            if (len > (64'd1 << (blk_log2 + top)))
            begin
                res.status = bma_pkg::ST_BIG;
                return res;
            end
            need = len + bma_pkg::HDR;
            k = 0;
            while (k < 40 && (64'd1 << k) < need) k++;
            need_lvl = k > blk_log2 ? k - blk_log2 : 0;
            if (need_lvl > top)
            begin
                res.status = bma_pkg::ST_NOBLK;
                return res;
            end
            for (l = need_lvl; l <= top && !found; l++)
            begin
                cnt = 32'd1 << (top - l);
                for (int unsigned i = 0; i < cnt && !found; i++)
                begin
                    if (free_bit[node_ix(top, l, i)])
                    begin
                        p = i;
                        found = 1;
                    end
                end
                if (found) break;
            end
            if (!found)
            begin
                res.status = bma_pkg::ST_NOBLK;
                return res;
            end
            free_bit[node_ix(top, l, p)] = 1'b0;
            while (l > need_lvl)
            begin
                l--;
                p = p << 1;
                free_bit[node_ix(top, l, p + 1)] = 1'b1;
            end
            idx = (p << need_lvl) & 32'h3FF;
            grant_lvl[idx] = 5'(need_lvl);
            lvl_written[idx] = 1'b1;
            res.payload_offset = 30'(((64'(idx) << blk_log2) + bma_pkg::HDR) & MASK30);
            res.status = bma_pkg::ST_OK;
        end
        else
        begin
            idx = release_index(r.release_offset);
            l = grant_lvl[idx];
            if (l > top) l = top;
            p = idx >> l;
            while (l < top && free_bit[node_ix(top, l, p ^ 1)])
            begin
                free_bit[node_ix(top, l, p ^ 1)] = 1'b0;
                p = p >> 1;
                l++;
            end
            free_bit[node_ix(top, l, p)] = 1'b1;
        end
        return res;
    endfunction

    task automatic issue(bma_pkg::req_t r, bit typed, bma_pkg::rsp_t typed_rsp);
        bma_pkg::rsp_t predicted;
        int gap;
        gap = 0;
        if ((idle_mode == 1 && $urandom_range(0, 99) < 56) ||
            (idle_mode == 3 && $urandom_range(0, 99) < 12))
            gap = $urandom_range(1, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= r;
        do @(posedge clk); while (!in_ready);
        predicted = buddy_predict(r);
        pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : predicted);
        if (r.kind == bma_pkg::KIND_ALLOC && predicted.status == bma_pkg::ST_OK)
        begin
            live_offsets.insert(live_offsets.size(), predicted.payload_offset);
            grants++;
        end
        else if (r.kind == bma_pkg::KIND_FREE)
            releases++;
        else
            refusals++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] ix, logic [4:0] val);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= ix;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (ix == 1'b0) blk_log2 = val;
        else pool_ord = val[3:0];
        clear_pool();
    endtask

    task automatic random_request(output bma_pkg::req_t r);
        int unsigned pick, j, top, e;
        longint unsigned hi;
        pick = $urandom_range(0, 99);
        r.kind = bma_pkg::KIND_ALLOC;
        r.request_length = 30'($urandom);
        r.release_offset = 30'($urandom);
        top = eff_top();
        if (live_offsets.size() > 0 && (pick < 40 || live_offsets.size() > 48))
        begin
            j = $urandom_range(0, live_offsets.size() - 1);
            r.kind = bma_pkg::KIND_FREE;
            r.release_offset = live_offsets[j];
            if ($urandom_range(0, 9) != 0) live_offsets.delete(j);
        end
        else if (pick < 43 && lvl_written[release_index(r.release_offset)])
        begin
            r.kind = bma_pkg::KIND_FREE;
        end
        else if (pick < 46)
        begin
            r.request_length = '0;
        end
        else if (pick >= 49)
        begin
            e = $urandom_range(0, blk_log2 + top);
            hi = 64'd1 << e;
            if (hi > MASK30) hi = MASK30;
            r.request_length = 30'($urandom_range(1, 32'(hi)));
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        case (idle_mode)
            2: out_ready <= $urandom_range(0, 99) >= 56;
            3: out_ready <= $urandom_range(0, 99) >= 12;
            default: out_ready <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin
        bma_pkg::rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            responses++;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response offset=%0d status=%0d",
                             out_rsp.payload_offset, out_rsp.status);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (out_rsp.payload_offset !== want.payload_offset ||
                    out_rsp.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("resp %0d: exp off=%0d st=%0d, got off=%0d st=%0d",
                                 responses, want.payload_offset, want.status,
                                 out_rsp.payload_offset, out_rsp.status);
                end
            end
        end
    end

    initial
    begin
        bma_pkg::req_t r;
        bma_pkg::rsp_t typed_rsp;
        mismatches = 0;
        responses = 0;
        grants = 0;
        releases = 0;
        refusals = 0;
        idle_mode = 0;
        blk_log2 = 7;
        pool_ord = 10;
        clear_pool();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            r.kind = plan[i].kind;
            r.request_length = plan[i].len;
            r.release_offset = plan[i].off;
            typed_rsp.payload_offset = plan[i].exp_off;
            typed_rsp.status = plan[i].exp_st;
            issue(r, plan[i].typed, typed_rsp);
        end

        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph > 0)
            begin
                write_reg(1'b0, 5'(phase_cfg[ph][0]));
                write_reg(1'b1, 5'(phase_cfg[ph][1]));
            end
            for (int n = 0; n < 148; n++)
            begin
                if (n % 37 == 0) idle_mode = (ph + n / 37) % 4;
                random_request(r);
                issue(r, 0, '0);
            end
        end

        settle();
        repeat (50) @(posedge clk);
        $display("ran %0d responses over 9 pool setups: %0d grants, %0d frees, %0d refusals",
                 responses, grants, releases, refusals);
        $display("mismatches: %0d, responses still awaited: %0d", mismatches,
                 pending_rsp.size());
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/bma_pkg.sv
hw/rtl/bma_ram.sv
hw/rtl/bma_ctrl.sv
hw/rtl/bma_dp.sv
hw/rtl/buddy_memory_allocator_core.sv
bench/buddy_memory_allocator_core_test.sv
